### hw/rtl/ace_pkg.sv
// shared types, codes and constants of the csi command executor
package ace_pkg;

   localparam int DIM_CAP  = 256;
   localparam int RST_ROWS = 24;
   localparam int RST_COLS = 80;
   localparam int ALU_W    = 18;

   localparam logic [1:0] REQ_PUSH  = 2'd0;
   localparam logic [1:0] REQ_EXEC  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] CSR_ROWS = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;

   localparam logic [7:0] CMD_SGR     = 8'h6D;
   localparam logic [7:0] CMD_UP      = 8'h41;
   localparam logic [7:0] CMD_DOWN    = 8'h42;
   localparam logic [7:0] CMD_FWD     = 8'h43;
   localparam logic [7:0] CMD_BACK    = 8'h44;
   localparam logic [7:0] CMD_POS     = 8'h48;
   localparam logic [7:0] CMD_POS_ALT = 8'h66;
   localparam logic [7:0] CMD_ED      = 8'h4A;
   localparam logic [7:0] CMD_EL      = 8'h4B;

   localparam logic [15:0] ERASE_TO_END   = 16'd0;
   localparam logic [15:0] ERASE_TO_START = 16'd1;
   localparam logic [15:0] ERASE_ALL      = 16'd2;

   localparam logic [15:0] SGR_RESET        = 16'd0;
   localparam logic [15:0] SGR_BOLD         = 16'd1;
   localparam logic [15:0] SGR_UNDERLINE    = 16'd4;
   localparam logic [15:0] SGR_BLINK        = 16'd5;
   localparam logic [15:0] SGR_REVERSE      = 16'd7;
   localparam logic [15:0] SGR_NO_BOLD      = 16'd22;
   localparam logic [15:0] SGR_NO_UNDERLINE = 16'd24;
   localparam logic [15:0] SGR_NO_BLINK     = 16'd25;
   localparam logic [15:0] SGR_NO_REVERSE   = 16'd27;
   localparam logic [15:0] SGR_FG_LO        = 16'd30;
   localparam logic [15:0] SGR_FG_HI        = 16'd37;
   localparam logic [15:0] SGR_FG_EXT       = 16'd38;
   localparam logic [15:0] SGR_FG_DEFAULT   = 16'd39;
   localparam logic [15:0] SGR_BG_LO        = 16'd40;
   localparam logic [15:0] SGR_BG_HI        = 16'd47;
   localparam logic [15:0] SGR_BG_EXT       = 16'd48;
   localparam logic [15:0] SGR_BG_DEFAULT   = 16'd49;
   localparam logic [15:0] SGR_EXT_INDEXED  = 16'd5;

   localparam logic [3:0] ATTR_BOLD      = 4'b0001;
   localparam logic [3:0] ATTR_UNDERLINE = 4'b0010;
   localparam logic [3:0] ATTR_BLINK     = 4'b0100;
   localparam logic [3:0] ATTR_REVERSE   = 4'b1000;

   localparam logic [7:0] FG_DEFAULT = 8'd7;
   localparam logic [7:0] BG_DEFAULT = 8'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ADJ,
      ST_CLAMP,
      ST_MUL,
      ST_ERA_START,
      ST_ERA_COUNT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_EXT_SEL,
      MODE_EXT_COLOR
   } sgr_mode_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_op_type;

   typedef struct packed {
      logic       we;
      logic [1:0] index;
      logic [8:0] wdata;
   } csr_wr_type;

   typedef struct packed {
      logic [7:0]  row;
      logic [7:0]  col;
      logic [7:0]  fg;
      logic [7:0]  bg;
      logic [3:0]  attr;
      logic        fill_valid;
      logic [15:0] fill_start;
      logic [16:0] fill_count;
      logic        ovf;
   } rsp_type;

endpackage

### hw/rtl/ace_if.sv
// handshake channels of the csi command executor
interface ace_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] param_value;
   logic [7:0]  cmd_byte;

   modport source (output valid, req_type, param_value, cmd_byte, input ready);
   modport sink (input valid, req_type, param_value, cmd_byte, output ready);
endinterface

interface ace_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  row_out;
   logic [7:0]  col_out;
   logic [7:0]  fg_out;
   logic [7:0]  bg_out;
   logic [3:0]  attr_out;
   logic        fill_valid;
   logic [15:0] fill_start;
   logic [16:0] fill_count;
   logic        param_overflow;

   modport source (output valid, row_out, col_out, fg_out, bg_out, attr_out, fill_valid,
                   fill_start, fill_count, param_overflow, input ready);
   modport sink (input valid, row_out, col_out, fg_out, bg_out, attr_out, fill_valid,
                 fill_start, fill_count, param_overflow, output ready);
endinterface

interface ace_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [8:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

### hw/rtl/ace_ram.sv
// generic single write port ram with registered read
module ace_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/ace_alu.sv
// shared add and subtract unit used for moves, clamps, products and spans
module ace_alu import ace_pkg::*; (
   input  alu_op_type       op,
   output logic [ALU_W-1:0] sum
);

   always_comb begin
      if (op.sub) begin
         sum = op.a - op.b;
      end else begin
         sum = op.a + op.b;
      end
   end

endmodule

### hw/rtl/ace_seq.sv
// sequencer and state of the csi command executor
module ace_seq import ace_pkg::*; #(
   parameter int MAX_PARAMS = 16,
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256,
   localparam int AW = $clog2(MAX_PARAMS),
   localparam int CW = $clog2(MAX_PARAMS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_type,
   input  logic [15:0]      param_value,
   input  logic [7:0]       cmd_byte,
   input  csr_wr_type       csr_wr,
   input  logic             out_free,
   output logic             idle,
   output logic             done,
   output rsp_type          result,
   output logic             ram_we,
   output logic [AW-1:0]    ram_waddr,
   output logic [15:0]      ram_wdata,
   output logic [AW-1:0]    ram_raddr,
   input  logic [15:0]      ram_rdata,
   output alu_op_type       alu_op,
   input  logic [ALU_W-1:0] alu_sum
);

   localparam int ROW_LIM  = MAX_ROWS < DIM_CAP ? MAX_ROWS : DIM_CAP;
   localparam int COL_LIM  = MAX_COLS < DIM_CAP ? MAX_COLS : DIM_CAP;
   localparam int ROWS_RST = RST_ROWS > ROW_LIM ? ROW_LIM : RST_ROWS;
   localparam int COLS_RST = RST_COLS > COL_LIM ? COL_LIM : RST_COLS;

   function automatic logic [8:0] eff_dim(input logic [8:0] v, input logic [8:0] lim);
      logic [8:0] r;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if (v > lim) begin
         r = lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   state_type    state_ff, state_in;
   sgr_mode_type mode_ff, mode_in;
   logic [7:0]   cmd_ff, cmd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic         rdv_ff, rdv_in;
   logic [15:0]  p0_ff, p0_in;
   logic [15:0]  p1_ff, p1_in;
   logic         ext_bg_ff, ext_bg_in;
   logic         phase_ff, phase_in;
   logic [16:0]  acc_ff, acc_in;
   logic [16:0]  mcand_ff, mcand_in;
   logic [8:0]   mplier_ff, mplier_in;
   logic [7:0]   row_ff, row_in;
   logic [7:0]   col_ff, col_in;
   logic [7:0]   fg_ff, fg_in;
   logic [7:0]   bg_ff, bg_in;
   logic [3:0]   attr_ff, attr_in;
   logic         fill_valid_ff, fill_valid_in;
   logic [15:0]  fill_start_ff, fill_start_in;
   logic [16:0]  fill_count_ff, fill_count_in;
   logic         ovf_ff, ovf_in;
   logic [8:0]   rows_ff, rows_in;
   logic [8:0]   cols_ff, cols_in;
   logic [7:0]   rows_m1_ff, rows_m1_in;
   logic [7:0]   cols_m1_ff, cols_m1_in;

   logic          is_sgr, is_up, is_down, is_fwd, is_back, is_pos, is_ed, is_el;
   logic          is_move, target_col;
   logic [CW-1:0] fetch_lim;
   logic          issue, fetch_done;
   logic          wide_ok, plain_step, store_full;
   logic [15:0]   n_val, p_sel;
   logic [15:0]   p;
   logic [8:0]    new_dim;
   logic [7:0]    new_m1, clamp_val, cur_sel, lim_m1;

   assign is_sgr  = cmd_ff == CMD_SGR;
   assign is_up   = cmd_ff == CMD_UP;
   assign is_down = cmd_ff == CMD_DOWN;
   assign is_fwd  = cmd_ff == CMD_FWD;
   assign is_back = cmd_ff == CMD_BACK;
   assign is_pos  = (cmd_ff == CMD_POS) || (cmd_ff == CMD_POS_ALT);
   assign is_ed   = cmd_ff == CMD_ED;
   assign is_el   = cmd_ff == CMD_EL;
   assign is_move = is_up || is_down || is_fwd || is_back;
   assign target_col = is_fwd || is_back || (is_pos && phase_ff);

   assign fetch_lim = is_sgr ? count_ff :
                      (count_ff > CW'(2) ? CW'(2) : count_ff);
   assign issue      = (state_ff == ST_FETCH) && (rd_idx_ff < fetch_lim);
   assign fetch_done = (state_ff == ST_FETCH) && !issue && !rdv_ff;
   assign wide_ok    = ({1'b0, rd_idx_ff} + (CW+1)'(1)) < {1'b0, count_ff};
   assign store_full = count_ff >= CW'(MAX_PARAMS);

   assign p          = ram_rdata;
   assign plain_step = (mode_ff == MODE_PLAIN) ||
                       ((mode_ff == MODE_EXT_SEL) && (p != SGR_EXT_INDEXED));

   assign n_val   = (p0_ff != 16'd0) ? p0_ff : 16'd1;
   assign p_sel   = phase_ff ? p1_ff : p0_ff;
   assign cur_sel = target_col ? col_ff : row_ff;
   assign lim_m1  = target_col ? cols_m1_ff : rows_m1_ff;

   assign new_dim = (csr_wr.index == CSR_ROWS) ? eff_dim(csr_wr.wdata, 9'(ROW_LIM)) :
                                                 eff_dim(csr_wr.wdata, 9'(COL_LIM));
   assign new_m1    = 8'(new_dim - 9'd1);
   assign clamp_val = alu_sum[ALU_W-1] ? lim_m1 : acc_ff[7:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_type == REQ_EXEC) ? ST_FETCH : ST_DONE;
            end
         end
         ST_FETCH: begin
            if (fetch_done) begin
               if (is_move || is_pos) begin
                  state_in = ST_ADJ;
               end else if (is_ed && (p0_ff == ERASE_ALL)) begin
                  state_in = ST_MUL;
               end else if (is_el && (p0_ff <= ERASE_ALL)) begin
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ADJ: begin
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            state_in = (is_pos && !phase_ff) ? ST_ADJ : ST_DONE;
         end
         ST_MUL: begin
            if (mplier_ff == 9'd0) begin
               state_in = is_ed ? ST_DONE : ST_ERA_START;
            end
         end
         ST_ERA_START: begin
            state_in = ST_ERA_COUNT;
         end
         ST_ERA_COUNT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs: handshake, ram ports and shared unit operands
   always_comb begin
      idle      = state_ff == ST_IDLE;
      done      = state_ff == ST_DONE;
      ram_we    = (state_ff == ST_IDLE) && start && (req_type == REQ_PUSH) && !store_full;
      ram_waddr = count_ff[AW-1:0];
      ram_wdata = param_value;
      ram_raddr = rd_idx_ff[AW-1:0];
      alu_op    = '0;
      case (state_ff)
         ST_ADJ: begin
            alu_op.a   = is_pos ? ALU_W'(p_sel) : ALU_W'(cur_sel);
            alu_op.b   = is_pos ? ALU_W'(1) : ALU_W'(n_val);
            alu_op.sub = is_pos || is_up || is_back;
         end
         ST_CLAMP: begin
            alu_op.a   = ALU_W'(lim_m1);
            alu_op.b   = ALU_W'(acc_ff);
            alu_op.sub = 1'b1;
         end
         ST_MUL: begin
            alu_op.a = ALU_W'(acc_ff);
            alu_op.b = mplier_ff[0] ? ALU_W'(mcand_ff) : '0;
         end
         ST_ERA_START: begin
            alu_op.a = ALU_W'(acc_ff);
            alu_op.b = ALU_W'(col_ff);
         end
         ST_ERA_COUNT: begin
            if (p0_ff == ERASE_TO_END) begin
               alu_op.a   = ALU_W'(cols_ff);
               alu_op.b   = ALU_W'(col_ff);
               alu_op.sub = 1'b1;
            end else if (p0_ff == ERASE_TO_START) begin
               alu_op.a = ALU_W'(col_ff);
               alu_op.b = ALU_W'(1);
            end else begin
               alu_op.a = ALU_W'(cols_ff);
            end
         end
         default: begin
            alu_op = '0;
         end
      endcase
      result.row        = row_ff;
      result.col        = col_ff;
      result.fg         = fg_ff;
      result.bg         = bg_ff;
      result.attr       = attr_ff;
      result.fill_valid = fill_valid_ff;
      result.fill_start = fill_start_ff;
      result.fill_count = fill_count_ff;
      result.ovf        = ovf_ff;
   end

   // datapath
   always_comb begin
      mode_in       = mode_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rdv_in        = rdv_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      ext_bg_in     = ext_bg_ff;
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      fg_in         = fg_ff;
      bg_in         = bg_ff;
      attr_in       = attr_ff;
      fill_valid_in = fill_valid_ff;
      fill_start_in = fill_start_ff;
      fill_count_in = fill_count_ff;
      ovf_in        = ovf_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      rows_m1_in    = rows_m1_ff;
      cols_m1_in    = cols_m1_ff;
      case (state_ff)
         ST_IDLE: begin
            if (csr_wr.we && (csr_wr.index == CSR_ROWS)) begin
               rows_in    = new_dim;
               rows_m1_in = new_m1;
               row_in     = (row_ff > new_m1) ? new_m1 : row_ff;
            end
            if (csr_wr.we && (csr_wr.index == CSR_COLS)) begin
               cols_in    = new_dim;
               cols_m1_in = new_m1;
               col_in     = (col_ff > new_m1) ? new_m1 : col_ff;
            end
            if (start) begin
               cmd_in        = cmd_byte;
               rd_idx_in     = '0;
               rdv_in        = 1'b0;
               mode_in       = MODE_PLAIN;
               phase_in      = 1'b0;
               p0_in         = '0;
               p1_in         = '0;
               fill_valid_in = 1'b0;
               fill_start_in = '0;
               fill_count_in = '0;
               ovf_in        = 1'b0;
               if (req_type == REQ_PUSH) begin
                  if (store_full) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end else if (req_type == REQ_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_FETCH: begin
            rd_idx_in = issue ? rd_idx_ff + CW'(1) : rd_idx_ff;
            rdv_in    = issue;
            if (rdv_ff && !is_sgr) begin
               if (rd_idx_ff == CW'(1)) begin
                  p0_in = p;
               end else begin
                  p1_in = p;
               end
            end
            if (rdv_ff && is_sgr) begin
               if (mode_ff == MODE_EXT_COLOR) begin
                  mode_in = MODE_PLAIN;
                  if (ext_bg_ff) begin
                     bg_in = p[7:0];
                  end else begin
                     fg_in = p[7:0];
                  end
               end else if (!plain_step) begin
                  mode_in = MODE_EXT_COLOR;
               end else begin
                  mode_in = MODE_PLAIN;
                  if (p == SGR_RESET) begin
                     fg_in   = FG_DEFAULT;
                     bg_in   = BG_DEFAULT;
                     attr_in = '0;
                  end else if (p == SGR_BOLD) begin
                     attr_in = attr_ff | ATTR_BOLD;
                  end else if (p == SGR_UNDERLINE) begin
                     attr_in = attr_ff | ATTR_UNDERLINE;
                  end else if (p == SGR_BLINK) begin
                     attr_in = attr_ff | ATTR_BLINK;
                  end else if (p == SGR_REVERSE) begin
                     attr_in = attr_ff | ATTR_REVERSE;
                  end else if (p == SGR_NO_BOLD) begin
                     attr_in = attr_ff & ~ATTR_BOLD;
                  end else if (p == SGR_NO_UNDERLINE) begin
                     attr_in = attr_ff & ~ATTR_UNDERLINE;
                  end else if (p == SGR_NO_BLINK) begin
                     attr_in = attr_ff & ~ATTR_BLINK;
                  end else if (p == SGR_NO_REVERSE) begin
                     attr_in = attr_ff & ~ATTR_REVERSE;
                  end else if ((p >= SGR_FG_LO) && (p <= SGR_FG_HI)) begin
                     fg_in = p[7:0] - SGR_FG_LO[7:0];
                  end else if ((p == SGR_FG_EXT) && wide_ok) begin
                     mode_in   = MODE_EXT_SEL;
                     ext_bg_in = 1'b0;
                  end else if (p == SGR_FG_DEFAULT) begin
                     fg_in = FG_DEFAULT;
                  end else if ((p >= SGR_BG_LO) && (p <= SGR_BG_HI)) begin
                     bg_in = p[7:0] - SGR_BG_LO[7:0];
                  end else if ((p == SGR_BG_EXT) && wide_ok) begin
                     mode_in   = MODE_EXT_SEL;
                     ext_bg_in = 1'b1;
                  end else if (p == SGR_BG_DEFAULT) begin
                     bg_in = BG_DEFAULT;
                  end
               end
            end
            if (fetch_done) begin
               if (is_sgr && (count_ff == '0)) begin
                  fg_in   = FG_DEFAULT;
                  bg_in   = BG_DEFAULT;
                  attr_in = '0;
               end
               acc_in    = '0;
               mcand_in  = 17'(cols_ff);
               mplier_in = is_ed ? rows_ff : {1'b0, row_ff};
            end
         end
         ST_ADJ: begin
            acc_in = alu_sum[ALU_W-1] ? '0 : alu_sum[16:0];
         end
         ST_CLAMP: begin
            if (target_col) begin
               col_in = clamp_val;
            end else begin
               row_in = clamp_val;
            end
            if (is_pos && !phase_ff) begin
               phase_in = 1'b1;
            end
         end
         ST_MUL: begin
            if (mplier_ff != 9'd0) begin
               acc_in    = alu_sum[16:0];
               mcand_in  = {mcand_ff[15:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[8:1]};
            end else if (is_ed) begin
               fill_valid_in = 1'b1;
               fill_start_in = '0;
               fill_count_in = acc_ff;
               row_in        = '0;
               col_in        = '0;
            end
         end
         ST_ERA_START: begin
            fill_valid_in = 1'b1;
            fill_start_in = (p0_ff == ERASE_TO_END) ? alu_sum[15:0] : acc_ff[15:0];
         end
         ST_ERA_COUNT: begin
            fill_count_in = alu_sum[16:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mode_ff    <= MODE_PLAIN;
         count_ff   <= '0;
         rd_idx_ff  <= '0;
         rdv_ff     <= 1'b0;
         phase_ff   <= 1'b0;
         row_ff     <= '0;
         col_ff     <= '0;
         fg_ff      <= FG_DEFAULT;
         bg_ff      <= BG_DEFAULT;
         attr_ff    <= '0;
         rows_ff    <= 9'(ROWS_RST);
         cols_ff    <= 9'(COLS_RST);
         rows_m1_ff <= 8'(ROWS_RST - 1);
         cols_m1_ff <= 8'(COLS_RST - 1);
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         count_ff   <= count_in;
         rd_idx_ff  <= rd_idx_in;
         rdv_ff     <= rdv_in;
         phase_ff   <= phase_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         fg_ff      <= fg_in;
         bg_ff      <= bg_in;
         attr_ff    <= attr_in;
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         rows_m1_ff <= rows_m1_in;
         cols_m1_ff <= cols_m1_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      p0_ff         <= p0_in;
      p1_ff         <= p1_in;
      ext_bg_ff     <= ext_bg_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      fill_valid_ff <= fill_valid_in;
      fill_start_ff <= fill_start_in;
      fill_count_ff <= fill_count_in;
      ovf_ff        <= ovf_in;
   end

endmodule

### hw/rtl/ansi_csi_command_executor.sv
// top level of the csi command executor
//
// req_if carries one beat per item: push a parameter, execute a final byte or
// clear the parameters. rsp_if returns exactly one beat per item with the
// cursor, colours, attributes, an optional erase span and the overflow flag.
// csr_if writes screen_rows (index 0) and screen_cols (index 1); it is ready
// only while the sequencer is idle, and the cursor is clamped into the new
// geometry in the same cycle.
// push, clear and unused request types go straight to the done state, and their
// beat is then registered in the output register. an execute first reads the
// parameter store one entry a cycle through the ram port (all entries for 'm',
// at most two otherwise), then uses the shared adder: an adjust and a clamp step
// per axis for cursor moves and positioning, and a shift-add product for an erase
// span, followed by a start and a count step for an erase in line.
// req_if is not ready while an item is in work; a finished beat waits in the
// output register, so the next item is taken while rsp_if stalls, and the
// sequencer holds its next result until that register frees up.
// synchronous reset clears the cursor, colours (fg 7, bg 0), attributes, the
// parameter count and the geometry (24 rows, 80 columns); no clearing pass.
module ansi_csi_command_executor import ace_pkg::*; #(
   parameter int MAX_PARAMS = 16,
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input logic       clock,
   input logic       reset,
   ace_req_if.sink   req_if,
   ace_rsp_if.source rsp_if,
   ace_csr_if.sink   csr_if
);

   localparam int AW = $clog2(MAX_PARAMS);

   logic             seq_idle, seq_done, out_free, load;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in, seq_result;
   csr_wr_type       csr_wr;
   logic             ram_we;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [15:0]      ram_wdata, ram_rdata;
   alu_op_type       alu_op;
   logic [ALU_W-1:0] alu_sum;

   assign req_if.ready = seq_idle;
   assign csr_if.ready = seq_idle;

   assign csr_wr.we    = csr_if.valid && seq_idle;
   assign csr_wr.index = csr_if.index;
   assign csr_wr.wdata = csr_if.wdata;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign load         = seq_done && out_free;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_if.ready);
   assign rsp_data_in  = load ? seq_result : rsp_data_ff;

   ace_seq #(
      .MAX_PARAMS (MAX_PARAMS),
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_if.valid && seq_idle),
      .req_type    (req_if.req_type),
      .param_value (req_if.param_value),
      .cmd_byte    (req_if.cmd_byte),
      .csr_wr      (csr_wr),
      .out_free    (out_free),
      .idle        (seq_idle),
      .done        (seq_done),
      .result      (seq_result),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .alu_op      (alu_op),
      .alu_sum     (alu_sum)
   );

   ace_ram #(
      .WIDTH (16),
      .DEPTH (MAX_PARAMS)
   ) u_param_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ace_alu u_alu (
      .op  (alu_op),
      .sum (alu_sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.row_out        = rsp_data_ff.row;
   assign rsp_if.col_out        = rsp_data_ff.col;
   assign rsp_if.fg_out         = rsp_data_ff.fg;
   assign rsp_if.bg_out         = rsp_data_ff.bg;
   assign rsp_if.attr_out       = rsp_data_ff.attr;
   assign rsp_if.fill_valid     = rsp_data_ff.fill_valid;
   assign rsp_if.fill_start     = rsp_data_ff.fill_start;
   assign rsp_if.fill_count     = rsp_data_ff.fill_count;
   assign rsp_if.param_overflow = rsp_data_ff.ovf;

endmodule

### sim/tb.sv
// self-checking testbench for the csi command executor: driver, monitor and status predictor
module tb import ace_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PARAM_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOW_LIMIT  = 10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] value;
      logic [7:0]  cmd;
   } csi_item_type;

   logic clock;
   logic reset;

   ace_req_if req_ch ();
   ace_rsp_if rsp_ch ();
   ace_csr_if csr_ch ();

   ansi_csi_command_executor dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   // predicted terminal state
   logic [8:0]  scr_rows;
   logic [8:0]  scr_cols;
   logic [15:0] params [PARAM_DEPTH];
   int unsigned nparams;
   logic [7:0]  crow;
   logic [7:0]  ccol;
   logic [7:0]  cfg;
   logic [7:0]  cbg;
   logic [3:0]  cattr;

   csi_item_type pending_q [$];
   rsp_type      status_due [$];
   csi_item_type on_wire;
   rsp_type      head_due;

   logic [7:0] exec_codes [9] = '{CMD_SGR, CMD_UP, CMD_DOWN, CMD_FWD, CMD_BACK,
                                  CMD_POS, CMD_POS_ALT, CMD_ED, CMD_EL};
   logic [8:0] rows_set [6] = '{9'd1, 9'd0, 9'd256, 9'd511, 9'd2, 9'd300};
   logic [8:0] cols_set [6] = '{9'd1, 9'd511, 9'd256, 9'd0, 9'd3, 9'd170};

   int  items_taken;
   int  results_checked;
   int  spans_due;
   int  drops_due;
   int  mismatches;
   int  hold_left;
   bit  hold_done;
   bit  calm;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned eff_dim(logic [8:0] v);
      if (v == 0) return 1;
      return v > DIM_CAP ? DIM_CAP : v;
   endfunction

   function automatic void sgr_defaults();
      cfg   = FG_DEFAULT;
      cbg   = BG_DEFAULT;
      cattr = 4'd0;
   endfunction

   function automatic rsp_type predict_status(csi_item_type it);
      rsp_type     r;
      int unsigned rows, cols, n, pr, pc, base, i;
      logic [15:0] p0, p;
      bit          ext;
      rows = eff_dim(scr_rows);
      cols = eff_dim(scr_cols);
      r    = '0;
      p0   = nparams != 0 ? params[0] : 16'd0;
      case (it.kind)
         REQ_PUSH: begin
            if (nparams < PARAM_DEPTH) begin
               params[nparams] = it.value;
               nparams++;
            end else begin
               r.ovf = 1'b1;
            end
         end
         REQ_CLEAR: nparams = 0;
         REQ_EXEC: begin
            case (it.cmd)
               CMD_SGR: begin
                  if (nparams == 0) sgr_defaults();
                  i = 0;
                  while (i < nparams) begin
                     p   = params[i];
                     ext = (i + 2 < nparams) && (params[i + 1] == SGR_EXT_INDEXED);
                     if (p == SGR_RESET) sgr_defaults();
                     else if (p == SGR_BOLD) cattr |= ATTR_BOLD;
                     else if (p == SGR_UNDERLINE) cattr |= ATTR_UNDERLINE;
                     else if (p == SGR_BLINK) cattr |= ATTR_BLINK;
                     else if (p == SGR_REVERSE) cattr |= ATTR_REVERSE;
                     else if (p == SGR_NO_BOLD) cattr &= ~ATTR_BOLD;
                     else if (p == SGR_NO_UNDERLINE) cattr &= ~ATTR_UNDERLINE;
                     else if (p == SGR_NO_BLINK) cattr &= ~ATTR_BLINK;
                     else if (p == SGR_NO_REVERSE) cattr &= ~ATTR_REVERSE;
                     else if (p >= SGR_FG_LO && p <= SGR_FG_HI) cfg = 8'(p - SGR_FG_LO);
                     else if (p == SGR_FG_EXT && ext) begin
                        cfg = params[i + 2][7:0];
                        i += 2;
                     end
                     else if (p == SGR_FG_DEFAULT) cfg = FG_DEFAULT;
                     else if (p >= SGR_BG_LO && p <= SGR_BG_HI) cbg = 8'(p - SGR_BG_LO);
                     else if (p == SGR_BG_EXT && ext) begin
                        cbg = params[i + 2][7:0];
                        i += 2;
                     end
                     else if (p == SGR_BG_DEFAULT) cbg = BG_DEFAULT;
                     i++;
                  end
               end
               CMD_UP, CMD_DOWN, CMD_FWD, CMD_BACK: begin
                  n = p0 != 0 ? p0 : 1;
                  case (it.cmd)
                     CMD_UP: crow = n > crow ? 8'd0 : 8'(crow - n);
                     CMD_DOWN: crow = (crow + n >= rows) ? 8'(rows - 1) : 8'(crow + n);
                     CMD_FWD: ccol = (ccol + n >= cols) ? 8'(cols - 1) : 8'(ccol + n);
                     default: ccol = n > ccol ? 8'd0 : 8'(ccol - n);
                  endcase
               end
               CMD_POS, CMD_POS_ALT: begin
                  pr   = nparams > 0 ? p0 : 1;
                  pc   = nparams > 1 ? params[1] : 1;
                  pr   = pr == 0 ? 0 : pr - 1;
                  pc   = pc == 0 ? 0 : pc - 1;
                  crow = pr >= rows ? 8'(rows - 1) : 8'(pr);
                  ccol = pc >= cols ? 8'(cols - 1) : 8'(pc);
               end
               CMD_ED: begin
                  if (p0 == ERASE_ALL) begin
                     r.fill_valid = 1'b1;
                     r.fill_count = 17'(rows * cols);
                     crow = 8'd0;
                     ccol = 8'd0;
                  end
               end
               CMD_EL: begin
                  base = crow * cols;
                  if (p0 == ERASE_TO_END) begin
                     r.fill_valid = 1'b1;
                     r.fill_start = 16'(base + ccol);
                     r.fill_count = 17'(cols - ccol);
                  end else if (p0 == ERASE_TO_START) begin
                     r.fill_valid = 1'b1;
                     r.fill_start = 16'(base);
                     r.fill_count = 17'(ccol + 1);
                  end else if (p0 == ERASE_ALL) begin
                     r.fill_valid = 1'b1;
                     r.fill_start = 16'(base);
                     r.fill_count = 17'(cols);
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.row  = crow;
      r.col  = ccol;
      r.fg   = cfg;
      r.bg   = cbg;
      r.attr = cattr;
      if (r.fill_valid) spans_due++;
      if (r.ovf) drops_due++;
      return r;
   endfunction

   function automatic void add_item(logic [1:0] kind, logic [15:0] value, logic [7:0] cmd);
      csi_item_type it;
      it.kind  = kind;
      it.value = value;
      it.cmd   = cmd;
      pending_q.push_back(it);
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(9))
         0: return 16'd0;
         6, 7: return 16'($urandom_range(300, 1));
         8: return 16'hFFFF;
         9: return 16'($urandom);
         default: return 16'($urandom_range(10, 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_sgr();
      return $urandom_range(9) != 0 ? 16'($urandom_range(50)) : 16'($urandom);
   endfunction

   function automatic void add_burst();
      int         sel, n;
      logic [7:0] op;
      sel = $urandom_range(99);
      if (sel < 70) begin
         op = exec_codes[$urandom_range(8)];
         if ($urandom_range(9) != 0) add_item(REQ_CLEAR, 16'($urandom), 8'($urandom));
         if (op == CMD_SGR) begin
            n = $urandom_range(5);
            for (int k = 0; k < n; k++) begin
               if ($urandom_range(4) == 0) begin
                  add_item(REQ_PUSH, $urandom_range(1) ? SGR_FG_EXT : SGR_BG_EXT, 8'($urandom));
                  add_item(REQ_PUSH, $urandom_range(5) != 0 ? SGR_EXT_INDEXED
                                                           : 16'($urandom_range(9)),
                           8'($urandom));
                  add_item(REQ_PUSH, 16'($urandom), 8'($urandom));
               end else begin
                  add_item(REQ_PUSH, pick_sgr(), 8'($urandom));
               end
            end
         end else if (op == CMD_ED || op == CMD_EL) begin
            if ($urandom_range(3) != 0)
               add_item(REQ_PUSH, $urandom_range(7) != 0 ? 16'($urandom_range(3))
                                                         : 16'($urandom),
                        8'($urandom));
         end else begin
            n = $urandom_range(2);
            for (int k = 0; k < n; k++) add_item(REQ_PUSH, pick_count(), 8'($urandom));
         end
         add_item(REQ_EXEC, 16'($urandom), op);
      end else if (sel < 82) begin
         // push 14 to 20 parameters, often overfilling the parameter store
         n = $urandom_range(20, 14);
         for (int k = 0; k < n; k++) add_item(REQ_PUSH, pick_sgr(), 8'($urandom));
         add_item(REQ_EXEC, 16'($urandom), exec_codes[$urandom_range(8)]);
      end else begin
         n = $urandom_range(4, 1);
         for (int k = 0; k < n; k++)
            add_item(2'($urandom_range(3)), 16'($urandom),
                     $urandom_range(3) != 0 ? 8'($urandom) : exec_codes[$urandom_range(8)]);
      end
   endfunction

   task automatic run_random(int target);
      int added, mark;
      added = 0;
      @(negedge clock);
      while (added < target) begin
         mark = pending_q.size();
         add_burst();
         added += pending_q.size() - mark;
      end
      while (pending_q.size() != 0 || req_ch.valid || status_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_geometry(logic [1:0] idx, logic [8:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_ROWS) scr_rows = val;
      else scr_cols = val;
      if (crow >= eff_dim(scr_rows)) crow = 8'(eff_dim(scr_rows) - 1);
      if (ccol >= eff_dim(scr_cols)) ccol = 8'(eff_dim(scr_cols) - 1);
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= SHOW_LIMIT)
            $display("mismatch on %s at beat %0d: expected %0d, got %0d",
                     name, results_checked, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            status_due.push_back(predict_status(on_wire));
            items_taken <= items_taken + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
               on_wire = pending_q.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.req_type    <= on_wire.kind;
               req_ch.param_value <= on_wire.value;
               req_ch.cmd_byte    <= on_wire.cmd;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long output stall once the run is under way
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && items_taken == 400) begin
         hold_left <= 250;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // status monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (status_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("status beat with nothing outstanding: row %0d col %0d",
                           rsp_ch.row_out, rsp_ch.col_out);
            end else begin
               head_due = status_due.pop_front();
               check_field("row_out", head_due.row, rsp_ch.row_out);
               check_field("col_out", head_due.col, rsp_ch.col_out);
               check_field("fg_out", head_due.fg, rsp_ch.fg_out);
               check_field("bg_out", head_due.bg, rsp_ch.bg_out);
               check_field("attr_out", head_due.attr, rsp_ch.attr_out);
               check_field("fill_valid", head_due.fill_valid, rsp_ch.fill_valid);
               check_field("fill_start", head_due.fill_start, rsp_ch.fill_start);
               check_field("fill_count", head_due.fill_count, rsp_ch.fill_count);
               check_field("param_overflow", head_due.ovf, rsp_ch.param_overflow);
               results_checked++;
            end
         end
         rsp_ch.ready <= hold_left == 0 && (calm || $urandom_range(99) >= 18);
      end
   end

   initial begin
      for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clock);
      $display("timed out after %0d cycles", CYCLE_LIMIT);
      $display("FAIL ansi_csi_command_executor");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_PUSH;
      req_ch.param_value = 16'd0;
      req_ch.cmd_byte    = 8'd0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_ROWS;
      csr_ch.wdata       = 9'd0;
      calm               = 1'b0;
      items_taken        = 0;
      results_checked    = 0;
      spans_due          = 0;
      drops_due          = 0;
      mismatches         = 0;
      scr_rows           = 9'(RST_ROWS);
      scr_cols           = 9'(RST_COLS);
      nparams            = 0;
      crow               = 8'd0;
      ccol               = 8'd0;
      sgr_defaults();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      add_item(REQ_EXEC, 16'd0, CMD_SGR);
      add_item(2'd3, 16'hFFFF, 8'hFF);
      add_item(REQ_EXEC, 16'hFFFF, 8'h00);
      add_item(REQ_PUSH, 16'hFFFF, 8'hFF);
      add_item(REQ_EXEC, 16'd0, CMD_DOWN);
      add_item(REQ_EXEC, 16'd0, CMD_FWD);
      add_item(REQ_EXEC, 16'd0, CMD_ED);
      add_item(REQ_CLEAR, 16'd0, 8'd0);
      add_item(REQ_EXEC, 16'd0, CMD_UP);
      add_item(REQ_EXEC, 16'd0, CMD_POS);
      add_item(REQ_PUSH, 16'd0, 8'd0);
      add_item(REQ_EXEC, 16'd0, CMD_BACK);
      add_item(REQ_EXEC, 16'd0, CMD_EL);
      add_item(REQ_CLEAR, 16'd0, 8'd0);
      add_item(REQ_PUSH, ERASE_ALL, 8'd0);
      add_item(REQ_EXEC, 16'd0, CMD_ED);
      add_item(REQ_CLEAR, 16'd0, 8'd0);
      add_item(REQ_PUSH, SGR_FG_EXT, 8'd0);
      add_item(REQ_PUSH, SGR_EXT_INDEXED, 8'd0);
      add_item(REQ_PUSH, 16'hABCD, 8'd0);
      add_item(REQ_EXEC, 16'd0, CMD_SGR);
      add_item(REQ_CLEAR, 16'd0, 8'd0);
      add_item(REQ_PUSH, 16'd7, 8'd0);
      add_item(REQ_PUSH, 16'd9, 8'd0);
      add_item(REQ_EXEC, 16'd0, CMD_POS_ALT);
      run_random(180);

      foreach (rows_set[g]) begin
         write_geometry(CSR_ROWS, rows_set[g]);
         write_geometry(CSR_COLS, cols_set[g]);
         calm <= g == 2;
         run_random(130);
      end
      calm <= 1'b0;
      write_geometry(CSR_ROWS, 9'($urandom_range(511)));
      write_geometry(CSR_COLS, 9'($urandom_range(511)));
      run_random(100);

      repeat (40) @(posedge clock);
      if (status_due.size() != 0) begin
         mismatches += status_due.size();
         $display("%0d status beats never arrived", status_due.size());
      end
      $display("%0d items in, %0d status beats checked, %0d erase spans, %0d dropped pushes",
               items_taken, results_checked, spans_due, drops_due);
      $display("geometries 1x1 to 256x256 incl. out-of-range registers, one long output stall");
      if (mismatches == 0) begin
         $display("PASS ansi_csi_command_executor");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAIL ansi_csi_command_executor");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/ace_pkg.sv
hw/rtl/ace_if.sv
hw/rtl/ace_ram.sv
hw/rtl/ace_alu.sv
hw/rtl/ace_seq.sv
hw/rtl/ansi_csi_command_executor.sv
sim/tb.sv
